/* hw/rtl/utf8_invisible_char_stripper_assert.svh */
// Assertion macros for the invisible character stripper.
// Included by the RTL modules that check their own logic; no other dependency.
`ifndef UTF8_INVISIBLE_CHAR_STRIPPER_ASSERT_SVH
`define UTF8_INVISIBLE_CHAR_STRIPPER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define UCS_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ucs assertion failed");

// consequent must hold in the cycle after the antecedent
`define UCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ucs assertion failed");

`else

`define UCS_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define UCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/ucs_pkg.sv */
// Shared types and constants for the invisible character stripper.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package ucs_pkg;

   // byte codes of the sequences being matched
   localparam logic [7:0] LEAD_NBSP   = 8'hC2;
   localparam logic [7:0] SECOND_NBSP = 8'hA0;
   localparam logic [7:0] LEAD_BOM    = 8'hEF;
   localparam logic [7:0] SECOND_BOM  = 8'hBB;
   localparam logic [7:0] THIRD_BOM   = 8'hBF;
   localparam logic [7:0] LEAD_ZW     = 8'hE2;
   localparam logic [7:0] SECOND_ZW   = 8'h80;
   localparam logic [7:0] THIRD_ZW_LO = 8'h8B;
   localparam logic [7:0] THIRD_ZW_HI = 8'h8F;
   localparam logic [7:0] SPACE_BYTE  = 8'h20;

   // most results one transaction can produce, and result queue depth
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // how many bytes of a candidate sequence are held back
   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_ONE  = 2'd1,
      HOLD_TWO  = 2'd2
   } hold_count_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       run_end;
      logic       text_end;
   } result_type;

   // results of one input transaction, handed to the result queue
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] item;
   } push_type;

   function automatic logic is_lead(input logic [7:0] b);
      return (b == LEAD_NBSP) || (b == LEAD_BOM) || (b == LEAD_ZW);
   endfunction

endpackage

/* hw/rtl/ucs_filter.sv */
// Sequence matcher: holds lead/second bytes and decodes one byte into results.
// Depends on ucs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_invisible_char_stripper_assert.svh"

module ucs_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         data_byte,
   input  logic               stream_last,
   output ucs_pkg::push_type  push
);

   logic [7:0]              held_lead_ff,   held_lead_in;
   logic [7:0]              held_second_ff, held_second_in;
   ucs_pkg::hold_count_type held_count_ff,  held_count_in;

   ucs_pkg::result_type [ucs_pkg::MAX_RESULTS-1:0] res;
   logic [1:0] n;
   logic       take_x;
   logic       match2;
   logic       drop3;

   // decode one byte against the held state
   always_comb begin
      res            = '0;
      n              = 2'd0;
      take_x         = 1'b0;
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      held_count_in  = held_count_ff;

      match2 = ((held_lead_ff == ucs_pkg::LEAD_BOM) && (data_byte == ucs_pkg::SECOND_BOM)) ||
               ((held_lead_ff == ucs_pkg::LEAD_ZW) && (data_byte == ucs_pkg::SECOND_ZW));
      drop3  = ((held_lead_ff == ucs_pkg::LEAD_BOM) && (data_byte == ucs_pkg::THIRD_BOM)) ||
               ((held_lead_ff == ucs_pkg::LEAD_ZW) && (data_byte >= ucs_pkg::THIRD_ZW_LO) &&
                (data_byte <= ucs_pkg::THIRD_ZW_HI));

      case (held_count_ff)
         ucs_pkg::HOLD_ONE: begin
            if ((held_lead_ff == ucs_pkg::LEAD_NBSP) &&
                (data_byte == ucs_pkg::SECOND_NBSP)) begin
               // no-break space becomes a plain space
               res[n].out_byte     = ucs_pkg::SPACE_BYTE;
               res[n].byte_present = 1'b1;
               n                   = n + 2'd1;
               held_lead_in        = '0;
               held_second_in      = '0;
               held_count_in       = ucs_pkg::HOLD_NONE;
            end else if (match2) begin
               held_second_in = data_byte;
               held_count_in  = ucs_pkg::HOLD_TWO;
            end else begin
               res[n].out_byte     = held_lead_ff;
               res[n].byte_present = 1'b1;
               n                   = n + 2'd1;
               take_x              = 1'b1;
            end
         end
         ucs_pkg::HOLD_TWO: begin
            if (drop3) begin
               held_lead_in   = '0;
               held_second_in = '0;
               held_count_in  = ucs_pkg::HOLD_NONE;
            end else begin
               res[n].out_byte     = held_lead_ff;
               res[n].byte_present = 1'b1;
               n                   = n + 2'd1;
               res[n].out_byte     = held_second_ff;
               res[n].byte_present = 1'b1;
               n                   = n + 2'd1;
               take_x              = 1'b1;
            end
         end
         default: begin
            take_x = 1'b1;
         end
      endcase

      // new byte examined afresh as a possible lead
      if (take_x) begin
         if (ucs_pkg::is_lead(data_byte)) begin
            held_lead_in   = data_byte;
            held_second_in = '0;
            held_count_in  = ucs_pkg::HOLD_ONE;
         end else begin
            res[n].out_byte     = data_byte;
            res[n].byte_present = 1'b1;
            n                   = n + 2'd1;
            held_lead_in        = '0;
            held_second_in      = '0;
            held_count_in       = ucs_pkg::HOLD_NONE;
         end
      end

      // end of text: flush held bytes, or emit an empty marker
      if (stream_last) begin
         if ((held_count_in == ucs_pkg::HOLD_ONE) || (held_count_in == ucs_pkg::HOLD_TWO)) begin
            res[n].out_byte     = held_lead_in;
            res[n].byte_present = 1'b1;
            n                   = n + 2'd1;
         end
         if (held_count_in == ucs_pkg::HOLD_TWO) begin
            res[n].out_byte     = held_second_in;
            res[n].byte_present = 1'b1;
            n                   = n + 2'd1;
         end
         held_lead_in   = '0;
         held_second_in = '0;
         held_count_in  = ucs_pkg::HOLD_NONE;
         if (n == 2'd0) begin
            n = 2'd1;
         end
         res[n - 2'd1].text_end = 1'b1;
      end

      if (n != 2'd0) begin
         res[n - 2'd1].run_end = 1'b1;
      end

      push.count = n;
      push.item  = res;
   end

   // held sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff   <= '0;
         held_second_ff <= '0;
         held_count_ff  <= ucs_pkg::HOLD_NONE;
      end else if (advance) begin
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
         held_count_ff  <= held_count_in;
      end
   end

   // a final byte always leaves nothing held
   `UCS_ASSERT_NEXT(a_last_clears, clock, reset, advance && stream_last, held_count_ff == ucs_pkg::HOLD_NONE)
   // the end marker is the only result without a byte
   `UCS_ASSERT_ALWAYS(a_marker_only_at_end, clock, reset, push.item[0].byte_present || push.count == 2'd0 || (stream_last && push.count == 2'd1))
   // a last transaction always produces at least one result
   `UCS_ASSERT_ALWAYS(a_last_has_result, clock, reset, !stream_last || push.count != 2'd0)

endmodule

/* hw/rtl/ucs_out_queue.sv */
// Result queue: takes up to three results per cycle given room, hands out one per cycle unless stalled.
// Depends on ucs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_invisible_char_stripper_assert.svh"

module ucs_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  ucs_pkg::push_type   push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ucs_pkg::result_type rsp_item
);

   ucs_pkg::result_type mem [ucs_pkg::QUEUE_DEPTH];

   logic [ucs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ucs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ucs_pkg::QCNT_W-1:0] count_ff,  count_in;
   logic [ucs_pkg::QCNT_W-1:0] count_after_pop;
   logic                       pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = mem[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // room for a full burst of results once this cycle's pop is done
   assign count_after_pop = count_ff - ucs_pkg::QCNT_W'(pop);
   assign room = (count_after_pop <= ucs_pkg::QCNT_W'(ucs_pkg::QUEUE_DEPTH - ucs_pkg::MAX_RESULTS));

   // pointer and fill count update
   always_comb begin
      rd_ptr_in = rd_ptr_ff + ucs_pkg::QPTR_W'(pop);
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_after_pop;
      if (push_en) begin
         wr_ptr_in = wr_ptr_ff + ucs_pkg::QPTR_W'(push.count);
         count_in  = count_after_pop + ucs_pkg::QCNT_W'(push.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the burst into consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < ucs_pkg::MAX_RESULTS; i++) begin
         if (push_en && (i < int'(push.count))) begin
            mem[wr_ptr_ff + ucs_pkg::QPTR_W'(i)] <= push.item[i];
         end
      end
   end

   `UCS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= ucs_pkg::QCNT_W'(ucs_pkg::QUEUE_DEPTH))
   `UCS_ASSERT_ALWAYS(a_push_fits, clock, reset, !push_en || room)

endmodule

/* hw/rtl/utf8_invisible_char_stripper.sv */
// An accepted transaction waits in the input register until its burst fits the queue.
// Throughput: one byte per cycle while each byte yields at most one result and rsp_stall
// is low; a byte that flushes held bytes is paced by the single-read result queue.
// Reset (synchronous, active high) empties the input register, the held sequence state
// and the result queue; the block takes a transaction in the first cycle after reset.
// Depends on ucs_pkg, ucs_filter, ucs_out_queue and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_invisible_char_stripper_assert.svh"

module utf8_invisible_char_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_run_end,
   output logic       rsp_text_end
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       room;
   logic       advance;
   logic       accept;

   ucs_pkg::push_type   push;
   ucs_pkg::result_type rsp_item;

   // input register drains into the result queue when a full burst fits
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_stream_last;
      end
   end

   ucs_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_data_ff),
      .stream_last (in_last_ff),
      .push        (push)
   );

   ucs_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_byte     = rsp_item.out_byte;
   assign rsp_byte_present = rsp_item.byte_present;
   assign rsp_run_end      = rsp_item.run_end;
   assign rsp_text_end     = rsp_item.text_end;

   // a transaction held in the input register is never lost while stalled
   `UCS_ASSERT_NEXT(a_hold_on_stall, clock, reset, req_stall, in_valid_ff)

endmodule

/* tb/tb_utf8_invisible_char_stripper.sv */
// Self-checking testbench for utf8_invisible_char_stripper: a directed byte run, then random
// text with random idles on both sides or one long receiver hold, checked against a built-in predictor.
// Depends on ucs_pkg and the utf8_invisible_char_stripper RTL.
`timescale 1ns / 1ps

module tb_utf8_invisible_char_stripper;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_stream_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_present;
   logic       rsp_run_end;
   logic       rsp_text_end;

   // bytes waiting to be offered, and cleaned output still to arrive
   text_byte_type          byte_feed[$];
   ucs_pkg::result_type    expected_out[$];
   ucs_pkg::result_type    step_out[$];

   // predictor copy of the held sequence
   ucs_pkg::hold_count_type hold_n      = ucs_pkg::HOLD_NONE;
   logic [7:0]              hold_lead   = 8'h00;
   logic [7:0]              hold_second = 8'h00;

   int  idle_mode      = 0;
   int  fail_count     = 0;
   int  cycle_count    = 0;
   int  long_hold_left = 0;
   bit  long_hold_done = 1'b0;
   bit  req_taken      = 1'b0;

   utf8_invisible_char_stripper dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_stream_last  (req_stream_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_run_end      (rsp_run_end),
      .rsp_text_end     (rsp_text_end)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic bit starts_sequence(input logic [7:0] b);
      return b == ucs_pkg::LEAD_NBSP || b == ucs_pkg::LEAD_BOM || b == ucs_pkg::LEAD_ZW;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      ucs_pkg::result_type r;
      r.out_byte     = b;
      r.byte_present = 1'b1;
      r.run_end      = 1'b0;
      r.text_end     = 1'b0;
      step_out.insert(step_out.size(), r);
   endtask

   // a lead is held, anything else goes straight out
   task automatic hold_or_pass(input logic [7:0] b);
      if (starts_sequence(b)) begin
         hold_lead   = b;
         hold_second = 8'h00;
         hold_n      = ucs_pkg::HOLD_ONE;
      end else begin
         add_byte(b);
      end
   endtask

   task automatic flush_hold();
      if (hold_n != ucs_pkg::HOLD_NONE) add_byte(hold_lead);
      if (hold_n == ucs_pkg::HOLD_TWO) add_byte(hold_second);
      hold_lead   = 8'h00;
      hold_second = 8'h00;
      hold_n      = ucs_pkg::HOLD_NONE;
   endtask

   // cleaned output of one input transaction, appended to expected_out
   task automatic strip_predict(input logic [7:0] x, input logic last);
      ucs_pkg::result_type r;
      bit                  drop;
      step_out.delete();
      case (hold_n)
         ucs_pkg::HOLD_ONE: begin
            if (hold_lead == ucs_pkg::LEAD_NBSP && x == ucs_pkg::SECOND_NBSP) begin
               hold_n    = ucs_pkg::HOLD_NONE;
               hold_lead = 8'h00;
               add_byte(ucs_pkg::SPACE_BYTE);
            end else if ((hold_lead == ucs_pkg::LEAD_BOM && x == ucs_pkg::SECOND_BOM) ||
                         (hold_lead == ucs_pkg::LEAD_ZW && x == ucs_pkg::SECOND_ZW)) begin
               hold_second = x;
               hold_n      = ucs_pkg::HOLD_TWO;
            end else begin
               flush_hold();
               hold_or_pass(x);
            end
         end
         ucs_pkg::HOLD_TWO: begin
            drop = (hold_lead == ucs_pkg::LEAD_BOM && x == ucs_pkg::THIRD_BOM) ||
                   (hold_lead == ucs_pkg::LEAD_ZW && x >= ucs_pkg::THIRD_ZW_LO &&
                    x <= ucs_pkg::THIRD_ZW_HI);
            if (drop) begin
               hold_lead   = 8'h00;
               hold_second = 8'h00;
               hold_n      = ucs_pkg::HOLD_NONE;
            end else begin
               flush_hold();
               hold_or_pass(x);
            end
         end
         default: begin
            hold_n = ucs_pkg::HOLD_NONE;
            hold_or_pass(x);
         end
      endcase
      // end of text: flush, or send an empty marker
      if (last) begin
         flush_hold();
         if (step_out.size() == 0) begin
            r = '0;
            step_out.insert(step_out.size(), r);
         end
         r = step_out.pop_back();
         r.text_end = 1'b1;
         step_out.insert(step_out.size(), r);
      end
      if (step_out.size() != 0) begin
         r = step_out.pop_back();
         r.run_end = 1'b1;
         step_out.insert(step_out.size(), r);
      end
      foreach (step_out[i]) expected_out.insert(expected_out.size(), step_out[i]);
   endtask

   // ---------------- check and predict at the rising edge ----------------

   always @(posedge clock) begin
      ucs_pkg::result_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         // compare the result transaction first, then predict the accepted byte
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               $error("unexpected result: out_byte %02h present %0b", rsp_out_byte,
                      rsp_byte_present);
               fail_count++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_byte_present !== want.byte_present) begin
                  $error("byte_present: expected %0b, got %0b", want.byte_present,
                         rsp_byte_present);
                  fail_count++;
               end
               if (rsp_run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_run_end);
                  fail_count++;
               end
               if (rsp_text_end !== want.text_end) begin
                  $error("text_end: expected %0b, got %0b", want.text_end, rsp_text_end);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) strip_predict(req_data_byte, req_stream_last);
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   // ---------------- driver ----------------

   function automatic int sender_idle_pct();
      return idle_mode == 0 ? 12 : (idle_mode == 1 ? 62 : 0);
   endfunction

   function automatic int receiver_idle_pct();
      return idle_mode == 0 ? 62 : (idle_mode == 1 ? 12 : 0);
   endfunction

   always @(negedge clock) begin
      text_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // a stalled transaction is held; otherwise offer the next byte or idle
         if (byte_feed.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
            nxt = byte_feed.pop_front();
            req_valid       <= 1'b1;
            req_data_byte   <= nxt.data;
            req_stream_last <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off in idle mode 2 while more than 20 bytes are still queued
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_left != 0) begin
         rsp_stall      <= 1'b1;
         long_hold_left <= long_hold_left - 1;
      end else if (idle_mode == 2 && !long_hold_done && byte_feed.size() > 20) begin
         rsp_stall      <= 1'b1;
         long_hold_left <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < receiver_idle_pct();
      end
   end

   // ---------------- stimulus ----------------

   task automatic feed(input logic [7:0] b, input logic last);
      text_byte_type t;
      t.data = b;
      t.last = last;
      byte_feed.insert(byte_feed.size(), t);
   endtask

   function automatic logic [7:0] random_lead();
      case ($urandom_range(0, 2))
         0: return ucs_pkg::LEAD_NBSP;
         1: return ucs_pkg::LEAD_BOM;
         default: return ucs_pkg::LEAD_ZW;
      endcase
   endfunction

   function automatic logic random_last();
      return $urandom_range(0, 11) == 0;
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // random bytes and complete sequences, plus broken sequences and lone leads
   task automatic queue_random_text(input int count);
      int         added;
      logic [7:0] lead;
      added = 0;
      while (added < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 9: begin
               feed(random_byte(), random_last());
               added += 1;
            end
            3: begin
               feed(ucs_pkg::LEAD_NBSP, random_last());
               feed(ucs_pkg::SECOND_NBSP, random_last());
               added += 2;
            end
            4: begin
               feed(ucs_pkg::LEAD_BOM, random_last());
               feed(ucs_pkg::SECOND_BOM, random_last());
               feed(ucs_pkg::THIRD_BOM, random_last());
               added += 3;
            end
            5: begin
               feed(ucs_pkg::LEAD_ZW, random_last());
               feed(ucs_pkg::SECOND_ZW, random_last());
               feed(8'($urandom_range(ucs_pkg::THIRD_ZW_LO, ucs_pkg::THIRD_ZW_HI)),
                    random_last());
               added += 3;
            end
            6: begin
               feed(random_lead(), random_last());
               feed(random_byte(), random_last());
               added += 2;
            end
            7: begin
               lead = $urandom_range(0, 1) ? ucs_pkg::LEAD_BOM : ucs_pkg::LEAD_ZW;
               feed(lead, random_last());
               feed(lead == ucs_pkg::LEAD_BOM ? ucs_pkg::SECOND_BOM : ucs_pkg::SECOND_ZW,
                    random_last());
               feed(random_byte(), random_last());
               added += 3;
            end
            default: begin
               feed(random_lead(), random_last());
               added += 1;
            end
         endcase
      end
   endtask

   // sender pause: nothing offered until every expected result is in
   task automatic wait_drained();
      while (byte_feed.size() != 0 || req_valid || expected_out.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pass-through extremes, each match, each kind of mismatch, text ends
      feed(8'h00, 1'b0);
      feed(8'hFF, 1'b0);
      feed(ucs_pkg::LEAD_NBSP, 1'b0);
      feed(ucs_pkg::SECOND_NBSP, 1'b0);
      feed(ucs_pkg::LEAD_BOM, 1'b0);
      feed(ucs_pkg::SECOND_BOM, 1'b0);
      feed(ucs_pkg::THIRD_BOM, 1'b0);
      feed(ucs_pkg::LEAD_ZW, 1'b0);
      feed(ucs_pkg::SECOND_ZW, 1'b0);
      feed(ucs_pkg::THIRD_ZW_LO, 1'b0);
      // third byte just below the range: all three come out
      feed(ucs_pkg::LEAD_ZW, 1'b0);
      feed(ucs_pkg::SECOND_ZW, 1'b0);
      feed(ucs_pkg::THIRD_ZW_LO - 8'h01, 1'b0);
      // lead breaks a held lead and is held afresh
      feed(ucs_pkg::LEAD_NBSP, 1'b0);
      feed(ucs_pkg::LEAD_NBSP, 1'b0);
      feed(ucs_pkg::SECOND_NBSP, 1'b0);
      feed(ucs_pkg::LEAD_BOM, 1'b0);
      feed(ucs_pkg::SECOND_BOM, 1'b0);
      feed(ucs_pkg::LEAD_ZW, 1'b0);
      feed(ucs_pkg::SECOND_ZW, 1'b0);
      // dropped sequence on the last byte gives the empty marker
      feed(ucs_pkg::THIRD_ZW_HI, 1'b1);
      feed(ucs_pkg::LEAD_BOM, 1'b1);
      // two held bytes plus a new lead flushed at the end: three results
      feed(ucs_pkg::LEAD_ZW, 1'b0);
      feed(ucs_pkg::SECOND_ZW, 1'b0);
      feed(ucs_pkg::LEAD_NBSP, 1'b1);
      feed(ucs_pkg::THIRD_ZW_HI + 8'h01, 1'b1);

      idle_mode = 0;
      queue_random_text(65);
      wait_drained();

      idle_mode = 1;
      queue_random_text(65);
      wait_drained();

      idle_mode = 2;
      queue_random_text(70);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ucs_pkg.sv
hw/rtl/ucs_filter.sv
hw/rtl/ucs_out_queue.sv
hw/rtl/utf8_invisible_char_stripper.sv
tb/tb_utf8_invisible_char_stripper.sv
